// File: rtl/ms_tri_pkg.sv
package ms_tri_pkg;

    localparam int MASK_W  = 16;
    localparam int FRAC_W  = 17;
    localparam int POINT_W = 3;
    localparam int NUM_CORNERS = 4;
    localparam int MAX_POINTS  = 6;

    typedef logic signed [MASK_W-1:0] mask_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic [POINT_W-1:0]       point_t;

    localparam logic [1:0] REG_MASK_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INVERT_MASK    = 2'd1;
    localparam logic [1:0] REG_UNIFORM_MODE   = 2'd2;

    localparam point_t PT_CORNER0 = 3'd0;
    localparam point_t PT_CORNER1 = 3'd1;
    localparam point_t PT_CORNER2 = 3'd2;
    localparam point_t PT_CORNER3 = 3'd3;
    localparam point_t PT_EDGE01  = 3'd4;

    typedef struct packed {
        logic [NUM_CORNERS-1:0] solid;
        logic                   uniform;
    } cell_ctrl_t;

endpackage

// File: rtl/ms_tri_ifs.sv
interface ms_tri_cell_if;
    logic                      valid;
    logic                      ready;
    ms_tri_pkg::mask_t         mask_corner0;
    ms_tri_pkg::mask_t         mask_corner1;
    ms_tri_pkg::mask_t         mask_corner2;
    ms_tri_pkg::mask_t         mask_corner3;

    modport source (output valid, mask_corner0, mask_corner1, mask_corner2, mask_corner3,
                    input ready);
    modport sink (input valid, mask_corner0, mask_corner1, mask_corner2, mask_corner3,
                  output ready);
endinterface

interface ms_tri_out_if;
    logic                      valid;
    logic                      ready;
    ms_tri_pkg::point_t        point_a;
    ms_tri_pkg::point_t        point_b;
    ms_tri_pkg::point_t        point_c;
    ms_tri_pkg::frac_t         frac_a;
    ms_tri_pkg::frac_t         frac_b;
    ms_tri_pkg::frac_t         frac_c;
    logic                      last_triangle;

    modport source (output valid, point_a, point_b, point_c, frac_a, frac_b, frac_c,
                    last_triangle, input ready);
    modport sink (input valid, point_a, point_b, point_c, frac_a, frac_b, frac_c,
                  last_triangle, output ready);
endinterface

// File: rtl/ms_tri_lane.sv
module ms_tri_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              en,
    input  ms_tri_pkg::mask_t thr,
    input  ms_tri_pkg::mask_t first,
    input  ms_tri_pkg::mask_t second,
    output ms_tri_pkg::frac_t frac
);
    import ms_tri_pkg::*;

    typedef enum logic [1:0] {MODE_ZERO, MODE_ONE, MODE_HALF, MODE_DIV} mode_t;

    logic signed [MASK_W:0] num;
    logic signed [MASK_W:0] den;
    logic signed [MASK_W:0] num_abs;
    logic signed [MASK_W:0] den_abs;
    mode_t                  mode;

    mode_t                  mode_reg [0:FRAC_BITS];
    logic [MASK_W-1:0]      rem_reg  [0:FRAC_BITS];
    logic [MASK_W-1:0]      dv_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]   q_reg    [0:FRAC_BITS];
    logic [FRAC_BITS:0]     full;

    always_comb
    begin
        num = {thr[MASK_W-1], thr} - {first[MASK_W-1], first};
        den = {second[MASK_W-1], second} - {first[MASK_W-1], first};
        if (den < 0)
        begin
            num_abs = -num;
            den_abs = -den;
        end
        else
        begin
            num_abs = num;
            den_abs = den;
        end
        priority if (den == '0)
            mode = MODE_HALF;
        else if (num_abs <= 0)
            mode = MODE_ZERO;
        else if (num_abs >= den_abs)
            mode = MODE_ONE;
        else
            mode = MODE_DIV;
    end

    // setup stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg[0] <= mode;
            rem_reg[0]  <= num_abs[MASK_W-1:0];
            dv_reg[0]   <= den_abs[MASK_W-1:0];
            q_reg[0]    <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= FRAC_BITS; s++)
    begin : g_div
        logic [MASK_W:0] rem2;
        logic            ge;

        assign rem2 = {rem_reg[s-1], 1'b0};
        assign ge   = rem2 >= {1'b0, dv_reg[s-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mode_reg[s] <= mode_reg[s-1];
                dv_reg[s]   <= dv_reg[s-1];
                rem_reg[s]  <= ge ? MASK_W'(rem2 - {1'b0, dv_reg[s-1]}) : rem2[MASK_W-1:0];
                q_reg[s]    <= {q_reg[s-1][FRAC_BITS-2:0], ge};
            end
        end
    end

    always_comb
    begin
        unique case (mode_reg[FRAC_BITS])
            MODE_ZERO: full = '0;
            MODE_ONE:  full = (FRAC_BITS+1)'(1) << FRAC_BITS;
            MODE_HALF: full = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
            MODE_DIV:  full = {1'b0, q_reg[FRAC_BITS]};
            default:   full = '0;
        endcase
    end

    assign frac = FRAC_W'(full);

endmodule

// File: rtl/ms_tri_merge.sv
module ms_tri_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ms_tri_pkg::cell_ctrl_t ctrl,
    input  ms_tri_pkg::frac_t      fracs [0:3],
    ms_tri_out_if.source           triangles
);
    import ms_tri_pkg::*;

    logic       busy_reg, busy_next;
    logic       quad_reg;
    logic [1:0] left_reg;
    point_t     pt_reg [0:MAX_POINTS-1];
    frac_t      fr_reg [0:MAX_POINTS-1];
    logic       out_valid_reg;

    point_t     pt_next [0:MAX_POINTS-1];
    frac_t      fr_next [0:MAX_POINTS-1];
    logic [2:0] n_pts;
    logic       quad;
    logic       emit;
    logic       load;

    always_comb
    begin
        n_pts = '0;
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            pt_next[k] = PT_CORNER0;
            fr_next[k] = '0;
        end
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            if (ctrl.solid[i])
            begin
                pt_next[n_pts] = point_t'(i);
                fr_next[n_pts] = '0;
                n_pts = n_pts + 3'd1;
            end
            if (ctrl.solid[i] != ctrl.solid[(i+1)%NUM_CORNERS])
            begin
                pt_next[n_pts] = PT_EDGE01 + point_t'(i);
                fr_next[n_pts] = fracs[i];
                n_pts = n_pts + 3'd1;
            end
        end
        quad = ctrl.uniform || (ctrl.solid == '1);
    end

    assign emit      = busy_reg && (!out_valid_reg || triangles.ready);
    assign in_ready  = !busy_reg || (emit && left_reg == 2'd0);
    assign load      = in_valid && in_ready;
    assign busy_next = ctrl.solid != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                busy_reg <= busy_next;
            else if (emit && left_reg == 2'd0)
                busy_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (triangles.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad;
            left_reg <= quad ? 2'd1 : 2'(n_pts - 3'd3);
            pt_reg   <= pt_next;
            fr_reg   <= fr_next;
        end
        else if (emit)
        begin
            left_reg <= left_reg - 2'd1;
            for (int k = 1; k < MAX_POINTS - 1; k++)
            begin
                pt_reg[k] <= pt_reg[k+1];
                fr_reg[k] <= fr_reg[k+1];
            end
        end

        if (emit)
        begin
            triangles.last_triangle <= left_reg == 2'd0;
            if (quad_reg)
            begin
                triangles.point_a <= PT_CORNER0;
                triangles.point_b <= (left_reg == 2'd1) ? PT_CORNER2 : PT_CORNER1;
                triangles.point_c <= (left_reg == 2'd1) ? PT_CORNER3 : PT_CORNER2;
                triangles.frac_a  <= '0;
                triangles.frac_b  <= '0;
                triangles.frac_c  <= '0;
            end
            else
            begin
                triangles.point_a <= pt_reg[0];
                triangles.point_b <= pt_reg[1];
                triangles.point_c <= pt_reg[2];
                triangles.frac_a  <= fr_reg[0];
                triangles.frac_b  <= fr_reg[1];
                triangles.frac_c  <= fr_reg[2];
            end
        end
    end

    assign triangles.valid = out_valid_reg;

endmodule

// File: rtl/marching_squares_cell_triangulator_core.sv
// marching squares cell triangulator
// corners: one word per grid cell, four signed Q8.8 corner masks in cell order
// triangles: one word per triangle, three point codes (corner 0-3, edge 4-7),
//   three Q1.FRAC_BITS edge fractions and a flag on the cell's final triangle
// cfg_*: write port for threshold (index 0), invert (1) and uniform mode (2)
// four lanes, one per cell edge, each run a pipelined restoring divider
//   giving one fraction bit per stage; a merge stage builds the polygon (or
//   the cell quad in uniform mode) and issues its fan triangles one per
//   cycle while the receiver takes them, through an output register
// a cell has 0 to 4 triangles; the merge stage takes the next cell as it
//   issues the current cell's last triangle, and it sets the rate
// cells with no triangle are dropped without any output word
// reset clears all valid state and sets the registers to threshold 0,
//   non-inverted, hybrid mode
// a stalled receiver holds the output word; the merge stage stops, and once
//   the last lane stage holds a cell the whole lane pipeline stops and corners.ready falls
module marching_squares_cell_triangulator_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    ms_tri_cell_if.sink         corners,
    ms_tri_out_if.source        triangles
);
    import ms_tri_pkg::*;

    mask_t      threshold_reg;
    logic       invert_reg;
    logic       uniform_reg;

    logic       valid_reg [0:FRAC_BITS];
    cell_ctrl_t ctrl_reg  [0:FRAC_BITS];

    mask_t      m [0:NUM_CORNERS-1];
    cell_ctrl_t ctrl_in;
    frac_t      fracs [0:NUM_CORNERS-1];
    logic       merge_ready;
    logic       adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            invert_reg    <= 1'b0;
            uniform_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MASK_THRESHOLD: threshold_reg <= mask_t'(cfg_data);
                REG_INVERT_MASK:    invert_reg    <= cfg_data[0];
                REG_UNIFORM_MODE:   uniform_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign m[0] = corners.mask_corner0;
    assign m[1] = corners.mask_corner1;
    assign m[2] = corners.mask_corner2;
    assign m[3] = corners.mask_corner3;

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
            ctrl_in.solid[i] = invert_reg ? (m[i] < threshold_reg) : (m[i] >= threshold_reg);
        ctrl_in.uniform = uniform_reg;
    end

    assign adv           = !valid_reg[FRAC_BITS] || merge_ready;
    assign corners.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= FRAC_BITS; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= corners.valid;
            for (int s = 1; s <= FRAC_BITS; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl_reg[0] <= ctrl_in;
            for (int s = 1; s <= FRAC_BITS; s++)
                ctrl_reg[s] <= ctrl_reg[s-1];
        end
    end

    for (genvar i = 0; i < NUM_CORNERS; i++)
    begin : g_lane
        ms_tri_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (adv),
            .thr    (threshold_reg),
            .first  (m[i]),
            .second (m[(i+1)%NUM_CORNERS]),
            .frac   (fracs[i])
        );
    end

    ms_tri_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[FRAC_BITS]),
        .in_ready  (merge_ready),
        .ctrl      (ctrl_reg[FRAC_BITS]),
        .fracs     (fracs),
        .triangles (triangles)
    );

endmodule
